FILE: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and codes for the TCP segment receive state machine.
// ----------------------------------------------------------------------------
package tsr_pkg;

    // Connection states
    localparam logic [3:0] ST_CLOSED    = 4'd0;
    localparam logic [3:0] ST_LISTEN    = 4'd1;
    localparam logic [3:0] ST_SYNSENT   = 4'd2;
    localparam logic [3:0] ST_SYNRCVD   = 4'd3;
    localparam logic [3:0] ST_ESTAB     = 4'd4;
    localparam logic [3:0] ST_FW1       = 4'd5;
    localparam logic [3:0] ST_FW2       = 4'd6;
    localparam logic [3:0] ST_CLOSEWAIT = 4'd7;
    localparam logic [3:0] ST_CLOSING   = 4'd8;
    localparam logic [3:0] ST_LASTACK   = 4'd9;
    localparam logic [3:0] ST_TIMEWAIT  = 4'd10;

    // Event codes on the input
    localparam logic [1:0] FUNC_SEGMENT   = 2'd0;
    localparam logic [1:0] FUNC_DATA_SENT = 2'd1;
    localparam logic [1:0] FUNC_FIN_SENT  = 2'd2;

    // Command kinds handed from front to back
    localparam logic [1:0] KIND_SEG  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RECEIVE_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_INITIAL_SEND_SEQ = 2'd1;
    localparam logic [1:0] CFG_OPEN_MODE        = 2'd2;

    // Open modes
    localparam logic [1:0] MODE_LISTEN  = 2'd1;
    localparam logic [1:0] MODE_SYNSENT = 2'd2;

    // Both internal queues hold two entries
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] length;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_rst;
        logic        flag_fin;
    } seg_t;

    typedef struct packed {
        logic [3:0]  conn_state_out;
        logic        send_ack;
        logic        send_reset;
        logic        send_synack;
        logic        deliver_payload;
        logic        una_advanced;
        logic [31:0] unacked_seq;
        logic        notify_reader;
        logic        connection_up;
    } result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_num;
        logic [31:0] seq_plus_one;
        logic [31:0] ack_num;
        logic [15:0] length;
        logic        len_nz;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_rst;
        logic        flag_fin;
    } cmd_t;

    typedef struct packed {
        logic [15:0] receive_window;
        logic [31:0] initial_send_seq;
        logic [1:0]  open_mode;
        logic        restart;
    } cfg_t;

endpackage

FILE: rtl/tcp_segment_receive_fsm.sv
// ----------------------------------------------------------------------------
// tcp_segment_receive_fsm
// Receive-side state machine of one TCP connection with queue-style ports.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            seg    (tsr_pkg::seg_t)
//  result    empty / pop            result (tsr_pkg::result_t)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One event per cycle is sustained while no queue is full and no restart is
//  pending; each result waits in the result queue until it is popped.
//  The back end updates the connection state once for each command it executes.
//  Two-entry queues on the command and result sides let each side stall alone.
//  Reset: closed state, window 65535, initial send sequence 0.
//  A write of open_mode sets a registered restart flag that restarts the
//  connection, and the back end holds its next command while the flag is set.
// ----------------------------------------------------------------------------
module tcp_segment_receive_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tsr_pkg::seg_t    seg,
    output logic             empty,
    input  logic             pop,
    output tsr_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    logic [15:0]   window_reg;
    logic [31:0]   isq_reg;
    logic [1:0]    mode_reg;
    logic          restart_reg;
    logic          cfg_write;
    logic          cmd_valid;
    logic          cmd_pop;
    tsr_pkg::cmd_t cmd;
    tsr_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= 16'hFFFF;
            isq_reg     <= 32'd0;
            mode_reg    <= 2'd0;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    tsr_pkg::CFG_RECEIVE_WINDOW:   window_reg <= cfg_data[15:0];
                    tsr_pkg::CFG_INITIAL_SEND_SEQ: isq_reg <= cfg_data;
                    tsr_pkg::CFG_OPEN_MODE:
                    begin
                        mode_reg    <= cfg_data[1:0];
                        restart_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.receive_window   = window_reg;
        cfg.initial_send_seq = isq_reg;
        cfg.open_mode        = mode_reg;
        cfg.restart          = restart_reg;
    end

    tsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .seg       (seg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: rtl/tsr_front.sv
// ----------------------------------------------------------------------------
// tsr_front
// Accepts input events, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tsr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tsr_pkg::seg_t seg,
    output logic          cmd_valid,
    output tsr_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    tsr_pkg::cmd_t entry_reg [2];
    tsr_pkg::cmd_t cmd_new;
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        cmd_new.seq_num      = seg.seq_num;
        cmd_new.seq_plus_one = seg.seq_num + 32'd1;
        cmd_new.ack_num      = seg.ack_num;
        cmd_new.length       = seg.length;
        cmd_new.len_nz       = (seg.length != 16'd0);
        cmd_new.flag_syn     = seg.flag_syn;
        cmd_new.flag_ack     = seg.flag_ack;
        cmd_new.flag_rst     = seg.flag_rst;
        cmd_new.flag_fin     = seg.flag_fin;
        unique case (seg.func)
            tsr_pkg::FUNC_SEGMENT:   cmd_new.kind = tsr_pkg::KIND_SEG;
            tsr_pkg::FUNC_DATA_SENT: cmd_new.kind = tsr_pkg::KIND_DATA;
            tsr_pkg::FUNC_FIN_SENT:  cmd_new.kind = tsr_pkg::KIND_FIN;
            default:                 cmd_new.kind = tsr_pkg::KIND_NOP;
        endcase
    end

    assign full      = (count_reg == tsr_pkg::QUEUE_DEPTH);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

FILE: rtl/tsr_back.sv
// ----------------------------------------------------------------------------
// tsr_back
// Executes one command per cycle against the connection state unless a restart
// is pending or the two-entry result queue is full, and queues the result there.
// ----------------------------------------------------------------------------
module tsr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tsr_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  tsr_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output tsr_pkg::result_t result
);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [31:0]      una_reg;
    logic [31:0]      una_next;
    logic [31:0]      nxt_reg;
    logic [31:0]      nxt_next;
    logic [31:0]      rnxt_reg;
    logic [31:0]      rnxt_next;
    logic [31:0]      irs_reg;
    logic [31:0]      irs_next;
    logic             fin_reg;
    logic             fin_next;
    tsr_pkg::result_t res_new;

    tsr_pkg::result_t res_entry_reg [2];
    logic             res_wr_ptr_reg;
    logic             res_rd_ptr_reg;
    logic [1:0]       res_count_reg;
    logic [1:0]       res_count_next;
    logic             exec;
    logic             do_pop;

    // A command waits while the connection restarts, so it sees the new state.
    assign exec    = cmd_valid && (res_count_reg != tsr_pkg::QUEUE_DEPTH) && !cfg.restart;
    assign cmd_pop = exec;
    assign do_pop  = pop && !empty;
    assign empty   = (res_count_reg == 2'd0);
    assign result  = res_entry_reg[res_rd_ptr_reg];

    always_comb
    begin
        logic [3:0]  st;
        logic [31:0] una;
        logic [31:0] nxt;
        logic [31:0] rn;
        logic [31:0] isq;
        logic [31:0] win_end;
        logic [31:0] ack;
        logic [31:0] seq;
        logic        go;
        logic        data;
        logic        o_ack;
        logic        o_rst;
        logic        o_synack;
        logic        o_deliver;
        logic        o_notify;
        logic        o_up;

        st        = state_reg;
        una       = una_reg;
        nxt       = nxt_reg;
        rn        = rnxt_reg;
        irs_next  = irs_reg;
        fin_next  = fin_reg;
        isq       = cfg.initial_send_seq;
        ack       = cmd.ack_num;
        seq       = cmd.seq_num;
        win_end   = rnxt_reg + {16'd0, cfg.receive_window};
        go        = 1'b0;
        data      = 1'b0;
        o_ack     = 1'b0;
        o_rst     = 1'b0;
        o_synack  = 1'b0;
        o_deliver = 1'b0;
        o_notify  = 1'b0;
        o_up      = 1'b0;

        unique case (cmd.kind)
            tsr_pkg::KIND_SEG:
            begin
                if (st == tsr_pkg::ST_CLOSED)
                begin
                    o_rst = !cmd.flag_rst;
                end
                else if (st == tsr_pkg::ST_LISTEN)
                begin
                    if (!cmd.flag_rst)
                    begin
                        if (cmd.flag_ack)
                        begin
                            o_rst = 1'b1;
                        end
                        else if (cmd.flag_syn)
                        begin
                            st       = tsr_pkg::ST_SYNRCVD;
                            irs_next = seq;
                            rn       = cmd.seq_plus_one;
                            nxt      = isq + 32'd1;
                            una      = isq;
                            o_synack = 1'b1;
                        end
                    end
                end
                else if (st == tsr_pkg::ST_SYNSENT)
                begin
                    if (cmd.flag_ack && (ack < isq || ack > nxt || ack < una))
                    begin
                        o_rst = !cmd.flag_rst;
                    end
                    else if (cmd.flag_rst)
                    begin
                        if (cmd.flag_ack)
                        begin
                            st = tsr_pkg::ST_CLOSED;
                        end
                    end
                    else if (cmd.flag_syn)
                    begin
                        rn       = cmd.seq_plus_one;
                        irs_next = seq;
                        if (cmd.flag_ack)
                        begin
                            una = ack;
                        end
                        if (una > isq)
                        begin
                            st    = tsr_pkg::ST_ESTAB;
                            una   = nxt;
                            o_ack = 1'b1;
                            o_up  = 1'b1;
                        end
                        else
                        begin
                            st       = tsr_pkg::ST_SYNRCVD;
                            una      = isq;
                            o_synack = 1'b1;
                        end
                    end
                end
                else
                begin
                    // Synchronized states start with the acceptance filter.
                    if ((cmd.len_nz && cfg.receive_window == 16'd0) || seq < rnxt_reg ||
                        seq > win_end)
                    begin
                        o_ack = !cmd.flag_rst;
                    end
                    else if (cmd.flag_rst)
                    begin
                        st = (st == tsr_pkg::ST_SYNRCVD && cfg.open_mode == tsr_pkg::MODE_LISTEN)
                            ? tsr_pkg::ST_LISTEN : tsr_pkg::ST_CLOSED;
                    end
                    else
                    begin
                        o_rst = cmd.flag_syn;
                        if (cmd.flag_ack)
                        begin
                            go = 1'b1;
                            if (st == tsr_pkg::ST_SYNRCVD)
                            begin
                                if (una <= ack && ack <= nxt)
                                begin
                                    una  = ack;
                                    st   = tsr_pkg::ST_ESTAB;
                                    o_up = 1'b1;
                                end
                                else
                                begin
                                    o_rst = 1'b1;
                                    go    = 1'b0;
                                end
                            end
                            else if (st != tsr_pkg::ST_TIMEWAIT)
                            begin
                                if (una < ack && ack <= nxt)
                                begin
                                    una = ack;
                                end
                                if (ack > nxt || ack < una)
                                begin
                                    go = 1'b0;
                                end
                                else if (una == nxt)
                                begin
                                    // Our FIN has been acknowledged.
                                    if (st == tsr_pkg::ST_FW1)
                                    begin
                                        st = tsr_pkg::ST_FW2;
                                    end
                                    else if (st == tsr_pkg::ST_CLOSING)
                                    begin
                                        st = tsr_pkg::ST_TIMEWAIT;
                                    end
                                    else if (st == tsr_pkg::ST_LASTACK)
                                    begin
                                        st = tsr_pkg::ST_CLOSED;
                                        go = 1'b0;
                                    end
                                end
                            end
                        end
                        if (go)
                        begin
                            data = (st == tsr_pkg::ST_ESTAB || st == tsr_pkg::ST_FW1 ||
                                    st == tsr_pkg::ST_FW2) && cmd.len_nz;
                            if (data)
                            begin
                                o_deliver = 1'b1;
                                o_notify  = 1'b1;
                                rn        = rn + {16'd0, cmd.length};
                            end
                            // An in-order FIN sits right after the payload.
                            if (cmd.flag_fin && (rn - {16'd0, cmd.length}) == seq)
                            begin
                                rn       = rn + 32'd1;
                                fin_next = 1'b1;
                                o_ack    = 1'b1;
                                o_notify = 1'b1;
                                if (st == tsr_pkg::ST_SYNRCVD || st == tsr_pkg::ST_ESTAB)
                                begin
                                    st = tsr_pkg::ST_CLOSEWAIT;
                                end
                                else if (st == tsr_pkg::ST_FW1)
                                begin
                                    st = tsr_pkg::ST_CLOSING;
                                end
                                else if (st == tsr_pkg::ST_FW2)
                                begin
                                    st = tsr_pkg::ST_TIMEWAIT;
                                end
                            end
                        end
                    end
                end
            end
            tsr_pkg::KIND_DATA:
            begin
                if (st == tsr_pkg::ST_ESTAB || st == tsr_pkg::ST_CLOSEWAIT)
                begin
                    nxt = nxt + {16'd0, cmd.length};
                end
            end
            tsr_pkg::KIND_FIN:
            begin
                if (st == tsr_pkg::ST_SYNRCVD || st == tsr_pkg::ST_ESTAB)
                begin
                    st  = tsr_pkg::ST_FW1;
                    nxt = nxt + 32'd1;
                end
                else if (st == tsr_pkg::ST_CLOSEWAIT)
                begin
                    st  = tsr_pkg::ST_LASTACK;
                    nxt = nxt + 32'd1;
                end
            end
            default:
            begin
            end
        endcase

        state_next = st;
        una_next   = una;
        nxt_next   = nxt;
        rnxt_next  = rn;

        res_new.conn_state_out  = st;
        res_new.send_ack        = o_ack;
        res_new.send_reset      = o_rst;
        res_new.send_synack     = o_synack;
        res_new.deliver_payload = o_deliver;
        res_new.una_advanced    = (una != una_reg);
        res_new.unacked_seq     = una;
        res_new.notify_reader   = o_notify;
        res_new.connection_up   = o_up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsr_pkg::ST_CLOSED;
            una_reg   <= 32'd0;
            nxt_reg   <= 32'd1;
            rnxt_reg  <= 32'd0;
            irs_reg   <= 32'd0;
            fin_reg   <= 1'b0;
        end
        else if (cfg.restart)
        begin
            if (cfg.open_mode == tsr_pkg::MODE_LISTEN)
            begin
                state_reg <= tsr_pkg::ST_LISTEN;
            end
            else if (cfg.open_mode == tsr_pkg::MODE_SYNSENT)
            begin
                state_reg <= tsr_pkg::ST_SYNSENT;
            end
            else
            begin
                state_reg <= tsr_pkg::ST_CLOSED;
            end
            una_reg  <= cfg.initial_send_seq;
            nxt_reg  <= cfg.initial_send_seq + 32'd1;
            rnxt_reg <= 32'd0;
            irs_reg  <= 32'd0;
            fin_reg  <= 1'b0;
        end
        else if (exec)
        begin
            state_reg <= state_next;
            una_reg   <= una_next;
            nxt_reg   <= nxt_next;
            rnxt_reg  <= rnxt_next;
            irs_reg   <= irs_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        res_count_next = res_count_reg + {1'b0, exec} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (exec)
            begin
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            end
            if (do_pop)
            begin
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_entry_reg[res_wr_ptr_reg] <= res_new;
        end
    end

    // The result queue never holds more than its two entries.
    a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= tsr_pkg::QUEUE_DEPTH)
        else $error("result queue overflow");

    // On entering synrcvd the receive pointer sits one past the peer's ISN.
    a_irs_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsr_pkg::ST_SYNRCVD && $past(state_reg) != tsr_pkg::ST_SYNRCVD)
        |-> (rnxt_reg == irs_reg + 32'd1))
        else $error("rcv_nxt does not follow irs on entering synrcvd");

    // Once the peer's FIN is in, only the closing side of the machine remains.
    a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (state_reg == tsr_pkg::ST_CLOSED || state_reg == tsr_pkg::ST_CLOSEWAIT ||
                     state_reg == tsr_pkg::ST_CLOSING || state_reg == tsr_pkg::ST_LASTACK ||
                     state_reg == tsr_pkg::ST_TIMEWAIT))
        else $error("FIN received but state still open for receive");

    // An executed command always leaves a result behind.
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> !empty)
        else $error("executed command produced no result");

endmodule
